>>> design/afrc_pkg.sv
// Package for the audio feedback ring control block.
// Holds ring geometry, feedback constants, operation codes and shared structs.
// No dependencies.
package afrc_pkg;

	localparam int RING_SLOTS    = 16;
	localparam int INTERVAL_LOG2 = 5;
	localparam int FB_FRAC_BITS  = 14;
	localparam int MCLK_LOG2     = 8;

	localparam int IDX_W = $clog2(RING_SLOTS);

	localparam logic [IDX_W-1:0] RING_LAST = IDX_W'(RING_SLOTS - 1);
	localparam logic [IDX_W-1:0] RING_HALF = IDX_W'(RING_SLOTS / 2);

	// Fill thresholds for the rate correction
	localparam logic [7:0] FILL_HI2 = 8'(RING_SLOTS - RING_SLOTS / 8);
	localparam logic [7:0] FILL_HI1 = 8'(RING_SLOTS - RING_SLOTS / 4);
	localparam logic [7:0] FILL_LO1 = 8'(RING_SLOTS / 4);
	localparam logic [7:0] FILL_LO2 = 8'(RING_SLOTS / 8);
	localparam logic [7:0] FILL_MAX = 8'd255;

	localparam logic [15:0] STEP_RESET = 16'd176;

	// Shift from master clocks per interval to 10.14 samples per frame
	localparam int FB_SHIFT   = FB_FRAC_BITS - (INTERVAL_LOG2 + MCLK_LOG2);
	localparam int FB_SHIFT_L = (FB_SHIFT >= 0) ? FB_SHIFT : 0;
	localparam int FB_SHIFT_R = (FB_SHIFT >= 0) ? 0 : -FB_SHIFT;

	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_STOP     = 3'd1,
		OP_PACKET   = 3'd2,
		OP_DONE     = 3'd3,
		OP_MEASURE  = 3'd4,
		OP_FEEDBACK = 3'd5
	} op_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [9:0]       wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} afrc_mem_req_t;

	typedef struct packed {
		logic [3:0]  write_slot;
		logic        play_issue;
		logic [3:0]  play_slot;
		logic        underrun;
		logic        feedback_send;
		logic [31:0] feedback_value;
		logic [7:0]  fill_level;
	} afrc_res_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		ring_next = (i == RING_LAST) ? '0 : i + IDX_W'(1);
	endfunction

endpackage

>>> design/audio_feedback_ring_control.sv
// Audio feedback ring control: packet ring and 10.14 rate feedback for an async sink.
// A result is registered in stage one and then in the output register before it shows on out_valid.
// Throughput: one transfer per cycle; only a stalled output register holds input off.
// The size store returns its read data registered, which sets the stage count.
// Reset (arst_n low) clears all control state, the per-slot valid bits at once
// (unwritten slots read as zero) and loads the correction step with 176.
module audio_feedback_ring_control (
	input  logic        clk,
	input  logic        arst_n,
	// configuration register: correction step
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [23:0] measured_count,
	input  logic [9:0]  packet_bytes,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  write_slot,
	output logic        play_issue,
	output logic [3:0]  play_slot,
	output logic [9:0]  play_bytes,
	output logic        underrun,
	output logic        feedback_send,
	output logic [31:0] feedback_value,
	output logic [7:0]  fill_level
);
	import afrc_pkg::*;

	logic          advance;
	logic          accept;
	afrc_mem_req_t mem_req;
	afrc_res_t     res;
	logic [9:0]    rdata;

	logic          valid_s1;
	afrc_res_t     res_s1;
	logic          out_valid_q;
	afrc_res_t     out_q;
	logic [9:0]    bytes_q;

	// The whole pipe moves when the output register is free or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = !advance;
	assign accept   = in_valid && advance;

	afrc_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.operation      (operation),
		.measured_count (measured_count),
		.packet_bytes   (packet_bytes),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mem_req        (mem_req),
		.res            (res)
	);

	// Slot sizes: written on packet transfers, read for issued slots
	afrc_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= accept;
			out_valid_q <= valid_s1;
		end
	end

	// Hold the result in stage one while the store read completes
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (advance && valid_s1) begin
			out_q   <= res_s1;
			bytes_q <= res_s1.play_issue ? rdata : 10'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign write_slot     = out_q.write_slot;
	assign play_issue     = out_q.play_issue;
	assign play_slot      = out_q.play_slot;
	assign play_bytes     = bytes_q;
	assign underrun       = out_q.underrun;
	assign feedback_send  = out_q.feedback_send;
	assign feedback_value = out_q.feedback_value;
	assign fill_level     = out_q.fill_level;

	a_under_issue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && underrun |-> play_issue)
		else $error("underrun without slot issue");

	a_bytes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !play_issue |-> (play_bytes == 10'd0))
		else $error("slot size shown without issue");

	a_fb_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !feedback_send |-> (feedback_value == 32'd0))
		else $error("feedback word shown without send");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid)
		else $error("stage one result lost");

endmodule

>>> design/afrc_slot_store.sv
// Packet size store: one synchronous memory of slot byte lengths.
// Per-entry valid bits make unwritten slots read as zero. Uses afrc_pkg.
module afrc_slot_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  afrc_pkg::afrc_mem_req_t req,
	output logic [9:0]            rdata
);
	import afrc_pkg::*;

	logic [9:0]            mem [RING_SLOTS];
	logic [RING_SLOTS-1:0] vld_q;
	logic [9:0]            rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	// Write and read in the same cycle: forward the new size on an address match
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			if (req.we && (req.waddr == req.raddr)) begin
				rdata_q <= req.wdata;
			end else if (!vld_q[req.raddr]) begin
				rdata_q <= '0;
			end else begin
				rdata_q <= mem[req.raddr];
			end
		end
	end

	assign rdata = rdata_q;

	a_vld_grows: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |=> vld_q[$past(req.waddr)])
		else $error("written slot not marked valid");

endmodule

>>> design/afrc_ctrl.sv
// Stream control: indices, fill count, start/stop flags and feedback word.
// Issues size store accesses and builds the result. Uses afrc_pkg.
module afrc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [2:0]              operation,
	input  logic [23:0]             measured_count,
	input  logic [9:0]              packet_bytes,
	input  logic                    cfg_we,
	input  logic [15:0]             cfg_wdata,
	output afrc_pkg::afrc_mem_req_t mem_req,
	output afrc_pkg::afrc_res_t     res
);
	import afrc_pkg::*;

	logic             playing_q, first_q, pending_q, fb_ready_q;
	logic [IDX_W-1:0] in_idx_q, out_idx_q;
	logic [7:0]       fill_q;
	logic [31:0]      fb_word_q;
	logic [15:0]      step_q;

	logic             playing_d, first_d, pending_d, fb_ready_d;
	logic [IDX_W-1:0] in_idx_d, out_idx_d;
	logic [7:0]       fill_d;
	logic [31:0]      fb_word_d;

	logic [31:0] c32, add_v, sub_v, meas_v;

	// Rate correction from the current fill level
	always_comb begin
		c32   = 32'(step_q);
		add_v = '0;
		sub_v = '0;
		if (fill_q == 8'd0) begin
			add_v = c32 << 2;
		end else begin
			if (fill_q >= FILL_HI2) sub_v = sub_v + (c32 << 1);
			if (fill_q >= FILL_HI1) sub_v = sub_v + c32;
			if (fill_q <= FILL_LO1) add_v = add_v + c32;
			if (fill_q <= FILL_LO2) add_v = add_v + (c32 << 1);
		end
		meas_v = 32'(measured_count) + add_v - sub_v;
	end

	always_comb begin
		playing_d  = playing_q;
		first_d    = first_q;
		pending_d  = pending_q;
		fb_ready_d = fb_ready_q;
		in_idx_d   = in_idx_q;
		out_idx_d  = out_idx_q;
		fill_d     = fill_q;
		fb_word_d  = fb_word_q;
		mem_req    = '0;
		res        = '0;
		case (op_t'(operation))
			OP_START: begin
				if (!playing_q) begin
					in_idx_d   = '0;
					out_idx_d  = '0;
					fill_d     = '0;
					pending_d  = 1'b1;
					first_d    = 1'b1;
					fb_ready_d = 1'b0;
				end
			end
			OP_STOP: begin
				if (playing_q) begin
					playing_d  = 1'b0;
					fb_ready_d = 1'b0;
				end
			end
			OP_PACKET: begin
				// First packet after start lands on the current slot
				if (!first_q) begin
					playing_d = 1'b1;
					if (fill_q != FILL_MAX) fill_d = fill_q + 8'd1;
					in_idx_d = ring_next(in_idx_q);
				end
				first_d        = 1'b0;
				mem_req.we     = 1'b1;
				mem_req.waddr  = in_idx_d;
				mem_req.wdata  = packet_bytes;
				res.write_slot = 4'(in_idx_d);
				if (pending_q && (in_idx_d >= RING_HALF)) begin
					pending_d      = 1'b0;
					res.play_issue = 1'b1;
					res.play_slot  = 4'(out_idx_q);
					mem_req.re     = 1'b1;
					mem_req.raddr  = out_idx_q;
				end
			end
			OP_DONE: begin
				if (playing_q) begin
					// Empty ring: replay the current slot
					if (fill_q != 8'd0) begin
						fill_d    = fill_q - 8'd1;
						out_idx_d = ring_next(out_idx_q);
					end else begin
						res.underrun = 1'b1;
					end
					res.play_issue = 1'b1;
					res.play_slot  = 4'(out_idx_d);
					mem_req.re     = 1'b1;
					mem_req.raddr  = out_idx_d;
				end
			end
			OP_MEASURE: begin
				fb_word_d  = (FB_SHIFT >= 0) ? (meas_v << FB_SHIFT_L) : (meas_v >> FB_SHIFT_R);
				fb_ready_d = 1'b1;
			end
			OP_FEEDBACK: begin
				if (fb_ready_q) begin
					res.feedback_send  = 1'b1;
					res.feedback_value = fb_word_q;
					fb_ready_d         = 1'b0;
				end
			end
			default: begin
			end
		endcase
		res.fill_level = fill_d;
		mem_req.we     = mem_req.we & accept;
		mem_req.re     = mem_req.re & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q  <= 1'b0;
			first_q    <= 1'b0;
			pending_q  <= 1'b0;
			fb_ready_q <= 1'b0;
			in_idx_q   <= '0;
			out_idx_q  <= '0;
			fill_q     <= '0;
			fb_word_q  <= '0;
			step_q     <= STEP_RESET;
		end else begin
			if (accept) begin
				playing_q  <= playing_d;
				first_q    <= first_d;
				pending_q  <= pending_d;
				fb_ready_q <= fb_ready_d;
				in_idx_q   <= in_idx_d;
				out_idx_q  <= out_idx_d;
				fill_q     <= fill_d;
				fb_word_q  <= fb_word_d;
			end
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
		end
	end

	a_stop_only: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(playing_q) |-> $past(accept && (operation == OP_STOP)))
		else $error("playback stopped without a stop transfer");

	a_start_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_q) |-> $past(accept && (operation == OP_START)))
		else $error("start pending set without a start transfer");

endmodule

>>> tb/sv/tb_audio_feedback_ring_control.sv
`timescale 1ns / 1ps
// Testbench for audio_feedback_ring_control: packet ring, playback hand-out and 10.14 feedback.
// Directed corner cases, then random stream sessions under several idling phases,
// checked against an in-bench ring predictor. Depends on afrc_pkg and the block only.
module tb_audio_feedback_ring_control;
	import afrc_pkg::*;

	// Codes the block must ignore (outside op_t)
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	// One result transfer as seen on the output port
	typedef struct packed {
		logic [3:0]  write_slot;
		logic        play_issue;
		logic [3:0]  play_slot;
		logic [9:0]  play_bytes;
		logic        underrun;
		logic        feedback_send;
		logic [31:0] feedback_value;
		logic [7:0]  fill_level;
	} ring_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  operation = '0;
	logic [23:0] measured_count = '0;
	logic [9:0]  packet_bytes = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  write_slot;
	logic        play_issue;
	logic [3:0]  play_slot;
	logic [9:0]  play_bytes;
	logic        underrun;
	logic        feedback_send;
	logic [31:0] feedback_value;
	logic [7:0]  fill_level;

	// Predictor state: mirrors the block after every accepted transfer
	logic [15:0]      corr_step = STEP_RESET;
	logic             ring_playing = 1'b0;
	logic             ring_first_packet = 1'b0;
	logic             ring_start_pending = 1'b0;
	logic             fb_ready = 1'b0;
	logic [IDX_W-1:0] wr_idx = '0;
	logic [IDX_W-1:0] rd_idx = '0;
	logic [7:0]       fill = '0;
	logic [9:0]       slot_len [RING_SLOTS] = '{default: '0};
	logic [31:0]      fb_word = '0;

	ring_result_t pending_results[$];
	int unsigned  error_count = 0;
	int unsigned  items_sent = 0;
	int unsigned  gap_pct = 0;
	int unsigned  stall_pct = 0;

	audio_feedback_ring_control dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.measured_count (measured_count),
		.packet_bytes   (packet_bytes),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.write_slot     (write_slot),
		.play_issue     (play_issue),
		.play_slot      (play_slot),
		.play_bytes     (play_bytes),
		.underrun       (underrun),
		.feedback_send  (feedback_send),
		.feedback_value (feedback_value),
		.fill_level     (fill_level)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Receiver back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(RING_SLOTS - 1)) ? '0 : idx + IDX_W'(1);
	endfunction

	// Advance the predictor by one event and return the result it must produce
	function automatic ring_result_t predict_ring_event(input logic [2:0] op,
			input logic [23:0] mclk, input logic [9:0] nbytes);
		ring_result_t res;
		logic [31:0]  rate;
		logic [31:0]  step32;
		res = '0;
		step32 = {16'd0, corr_step};
		case (op)
			OP_START: begin
				// restart only from idle; a start while playing changes nothing
				if (!ring_playing) begin
					wr_idx = '0;
					rd_idx = '0;
					fill = '0;
					ring_start_pending = 1'b1;
					ring_first_packet = 1'b1;
					fb_ready = 1'b0;
				end
			end
			OP_STOP: begin
				if (ring_playing) begin
					fb_ready = 1'b0;
					ring_playing = 1'b0;
				end
			end
			OP_PACKET: begin
				// first packet after start lands on the current slot without advancing
				if (!ring_first_packet) begin
					ring_playing = 1'b1;
					if (fill != FILL_MAX)
						fill = fill + 8'd1;
					wr_idx = wrap_next(wr_idx);
				end
				ring_first_packet = 1'b0;
				slot_len[wr_idx] = nbytes;
				res.write_slot = 4'(wr_idx);
				// half the ring written: hand the first slot to the output
				if (ring_start_pending && wr_idx >= RING_HALF) begin
					ring_start_pending = 1'b0;
					res.play_issue = 1'b1;
					res.play_slot = 4'(rd_idx);
					res.play_bytes = slot_len[rd_idx];
				end
			end
			OP_DONE: begin
				if (ring_playing) begin
					// empty ring: replay the current slot and flag it
					if (fill != 8'd0) begin
						fill = fill - 8'd1;
						rd_idx = wrap_next(rd_idx);
					end else begin
						res.underrun = 1'b1;
					end
					res.play_issue = 1'b1;
					res.play_slot = 4'(rd_idx);
					res.play_bytes = slot_len[rd_idx];
				end
			end
			OP_MEASURE: begin
				// correct by steps chosen from the fill level; everything wraps at 32 bits
				rate = {8'd0, mclk};
				if (fill != 8'd0) begin
					if (fill >= FILL_HI2)
						rate = rate - step32 * 32'd2;
					if (fill >= FILL_HI1)
						rate = rate - step32;
					if (fill <= FILL_LO1)
						rate = rate + step32;
					if (fill <= FILL_LO2)
						rate = rate + step32 * 32'd2;
				end else begin
					rate = rate + step32 * 32'd4;
				end
				fb_word = (rate << FB_SHIFT_L) >> FB_SHIFT_R;
				fb_ready = 1'b1;
			end
			OP_FEEDBACK: begin
				if (fb_ready) begin
					res.feedback_send = 1'b1;
					res.feedback_value = fb_word;
					fb_ready = 1'b0;
				end
			end
			default: ;
		endcase
		res.fill_level = fill;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Match every result transfer against the oldest outstanding prediction
	always @(posedge clk) begin : result_check
		ring_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: expected none, actual fill %0h",
					$time, fill_level);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("write_slot", 32'(want.write_slot), 32'(write_slot));
				check_field("play_issue", 32'(want.play_issue), 32'(play_issue));
				check_field("play_slot", 32'(want.play_slot), 32'(play_slot));
				check_field("play_bytes", 32'(want.play_bytes), 32'(play_bytes));
				check_field("underrun", 32'(want.underrun), 32'(underrun));
				check_field("feedback_send", 32'(want.feedback_send),
					32'(feedback_send));
				check_field("feedback_value", want.feedback_value, feedback_value);
				check_field("fill_level", 32'(want.fill_level), 32'(fill_level));
			end
		end
	end

	// Offer one event, hold it until the transfer, then record its prediction.
	// Valid stays high after the transfer unless the next call opens a gap.
	task automatic send_event(input logic [2:0] op, input logic [23:0] mclk,
			input logic [9:0] nbytes);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		measured_count <= mclk;
		packet_bytes <= nbytes;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_ring_event(op, mclk, nbytes));
		items_sent++;
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_correction_step(input logic [15:0] value);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		corr_step = value;
	endtask

	function automatic logic [23:0] rand_count();
		case ($urandom_range(9))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [9:0] rand_bytes();
		case ($urandom_range(9))
			0: return 10'd0;
			1: return 10'h3FF;
			default: return 10'($urandom);
		endcase
	endfunction

	function automatic logic [2:0] noise_op();
		case ($urandom_range(3))
			0: return OP_START;
			1: return OP_STOP;
			2: return OP_SPARE6;
			default: return OP_SPARE7;
		endcase
	endfunction

	// One stream: stop, start, then a mix biased toward filling or draining the ring
	task automatic run_session(input int unsigned pkt_pct, input int unsigned done_pct,
			input int unsigned len);
		int unsigned pick;
		send_event(OP_STOP, rand_count(), rand_bytes());
		send_event(OP_START, rand_count(), rand_bytes());
		repeat (len) begin
			pick = $urandom_range(99);
			if (pick < pkt_pct)
				send_event(OP_PACKET, rand_count(), rand_bytes());
			else if (pick < pkt_pct + done_pct)
				send_event(OP_DONE, rand_count(), rand_bytes());
			else if (pick < pkt_pct + done_pct + 12)
				send_event(OP_MEASURE, rand_count(), rand_bytes());
			else if (pick < pkt_pct + done_pct + 22)
				send_event(OP_FEEDBACK, rand_count(), rand_bytes());
			else
				send_event(noise_op(), rand_count(), rand_bytes());
		end
	endtask

	// Events while stopped or before any start, ignored codes, feedback without a word
	task automatic test_idle_corner_cases();
		send_event(OP_PACKET, 24'h000000, 10'h3FF);   // packet before any start advances
		send_event(OP_DONE, 24'hFFFFFF, 10'h000);
		send_event(OP_DONE, 24'h000000, 10'h3FF);     // ring empty: underrun and replay
		send_event(OP_SPARE6, 24'hFFFFFF, 10'h3FF);
		send_event(OP_SPARE7, 24'h000000, 10'h000);
		send_event(OP_FEEDBACK, 24'h000000, 10'h000); // no word yet: empty packet
		send_event(OP_MEASURE, 24'hFFFFFF, 10'h000);  // empty ring: largest boost
		send_event(OP_FEEDBACK, 24'h000000, 10'h000);
		send_event(OP_START, 24'h555555, 10'h155);    // start while playing is ignored
		send_event(OP_STOP, 24'hAAAAAA, 10'h2AA);
		send_event(OP_STOP, 24'h000000, 10'h000);     // stop while idle is ignored
		send_event(OP_DONE, 24'h000000, 10'h000);     // done while stopped issues nothing
	endtask

	// Start, fill up to half the ring so playback begins, then measure and report
	task automatic test_ring_startup();
		send_event(OP_START, 24'h000000, 10'h000);
		send_event(OP_PACKET, 24'h000000, 10'h000);
		send_event(OP_PACKET, 24'h000000, 10'h3FF);
		send_event(OP_PACKET, 24'h000000, 10'h155);
		send_event(OP_PACKET, 24'h000000, 10'h2AA);
		repeat (5) send_event(OP_PACKET, 24'($urandom), 10'($urandom));
		send_event(OP_MEASURE, 24'h000000, 10'h000);
		send_event(OP_FEEDBACK, 24'hFFFFFF, 10'h3FF);
	endtask

	// Flood the ring past 255 packets, measure at full fill, then drain a little
	task automatic test_fill_saturation();
		send_event(OP_STOP, rand_count(), rand_bytes());
		send_event(OP_START, rand_count(), rand_bytes());
		repeat (270) send_event(OP_PACKET, rand_count(), rand_bytes());
		send_event(OP_MEASURE, rand_count(), rand_bytes());
		send_event(OP_FEEDBACK, rand_count(), rand_bytes());
		repeat (12) send_event(OP_DONE, rand_count(), rand_bytes());
		send_event(OP_MEASURE, rand_count(), rand_bytes());
		send_event(OP_FEEDBACK, rand_count(), rand_bytes());
	endtask

	// Random sessions under one idling pattern and one correction step
	task automatic test_random_traffic(input int unsigned sender_gap,
			input int unsigned receiver_stall, input logic [15:0] step,
			input int unsigned count);
		int unsigned first;
		int unsigned pkt_pct;
		write_correction_step(step);
		gap_pct = sender_gap;
		stall_pct = receiver_stall;
		first = items_sent;
		while (items_sent - first < count) begin
			pkt_pct = $urandom_range(25, 60);
			run_session(pkt_pct, 70 - pkt_pct, $urandom_range(10, 60));
		end
	endtask

	initial begin
		// hold reset low, then release it on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_corner_cases();
		test_ring_startup();
		test_fill_saturation();
		test_random_traffic(0, 0, 16'hFFFF, 280);
		test_random_traffic(80, 0, 16'h0000, 280);
		test_random_traffic(0, 80, 16'($urandom), 280);
		test_random_traffic(30, 30, 16'($urandom), 280);

		drain_results();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
